/* rtl/scsa_pkg.sv */
// ----------------------------------------------------------------------------
// scsa_pkg: shared definitions for the size class slot allocator
// Sizes of the pool, result codes, register indexes, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package scsa_pkg;

  // Pool geometry
  localparam int SLOTS   = 100;
  localparam int BLOCKS  = 8;
  localparam int BLK_W   = $clog2(BLOCKS);
  localparam int SLOT_W  = 7;
  localparam int SIZE_W  = 16;

  // Free slot search looks at one chunk of a block's occupancy row per cycle
  localparam int CHUNK   = 8;
  localparam int CHUNK_B = $clog2(CHUNK);
  localparam int NCHUNK  = (SLOTS + CHUNK - 1) / CHUNK;
  localparam int CHUNK_W = SLOT_W - CHUNK_B;
  localparam int ROW_W   = NCHUNK * CHUNK;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TINY_CAP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_CAP = 1'b1;
  localparam logic [SIZE_W-1:0] TINY_CAP_RESET  = 16'd128;
  localparam logic [SIZE_W-1:0] SMALL_CAP_RESET = 16'd1024;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_NO_BLOCK  = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_REL,
    S_SCAN,
    S_NOFIT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    ld_req;
    logic    free_clear;
    logic    rel_step;
    logic    open_first;
    logic    scan_step;
    logic    nofit;
    logic    res_direct;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic op_free;
    logic size_zero;
    logic any_active;
    logic hit;
    logic scan_end;
    logic rel_last;
  } stat_t;

endpackage

/* rtl/scsa_if.sv */
// ----------------------------------------------------------------------------
// scsa channel interfaces
// Valid/ready channels for requests and for results.
// ----------------------------------------------------------------------------
interface scsa_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [scsa_pkg::SIZE_W-1:0]      request_size;
  logic [scsa_pkg::BLK_W-1:0]       block_index;
  logic [scsa_pkg::SLOT_W-1:0]      slot_index;

  modport source (output valid, operation, request_size, block_index, slot_index,
                  input ready);
  modport sink   (input valid, operation, request_size, block_index, slot_index,
                  output ready);
endinterface

interface scsa_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [scsa_pkg::BLK_W-1:0]       granted_block;
  logic [scsa_pkg::SLOT_W-1:0]      granted_slot;

  modport source (output valid, status, granted_block, granted_slot, input ready);
  modport sink   (input valid, status, granted_block, granted_slot, output ready);
endinterface

/* rtl/scsa_ctrl.sv */
// ----------------------------------------------------------------------------
// scsa_ctrl: allocator controller
// Sequences one transaction at a time through free, release, scan and
// block opening, and owns the result valid flag.
// ----------------------------------------------------------------------------
module scsa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  scsa_pkg::stat_t  stat,
  output scsa_pkg::cmd_t   cmd
);

  scsa_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_space;

  assign out_space = !out_valid_r || out_ready;
  assign in_ready  = (state_r == scsa_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scsa_pkg::S_IDLE: begin
        if (in_valid) state_nxt = scsa_pkg::S_START;
      end
      scsa_pkg::S_START: begin
        if (stat.op_free)        state_nxt = scsa_pkg::S_REL;
        else if (stat.size_zero) state_nxt = scsa_pkg::S_DONE;
        else                     state_nxt = scsa_pkg::S_SCAN;
      end
      scsa_pkg::S_REL: begin
        if (stat.rel_last) state_nxt = scsa_pkg::S_DONE;
      end
      scsa_pkg::S_SCAN: begin
        if (stat.hit)           state_nxt = scsa_pkg::S_DONE;
        else if (stat.scan_end) state_nxt = scsa_pkg::S_NOFIT;
      end
      scsa_pkg::S_NOFIT: state_nxt = scsa_pkg::S_DONE;
      scsa_pkg::S_DONE: begin
        if (out_space) state_nxt = scsa_pkg::S_IDLE;
      end
      default: state_nxt = scsa_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.res_code = scsa_pkg::ST_OK;
    unique case (state_r)
      scsa_pkg::S_IDLE: cmd.ld_req = in_valid;
      scsa_pkg::S_START: begin
        if (stat.op_free) begin
          cmd.free_clear = 1'b1;
          cmd.res_direct = 1'b1;
          cmd.res_code   = scsa_pkg::ST_OK;
        end else if (stat.size_zero) begin
          cmd.res_direct = 1'b1;
          cmd.res_code   = scsa_pkg::ST_ZERO;
        end else begin
          cmd.open_first = !stat.any_active;
        end
      end
      scsa_pkg::S_REL:   cmd.rel_step  = 1'b1;
      scsa_pkg::S_SCAN:  cmd.scan_step = 1'b1;
      scsa_pkg::S_NOFIT: cmd.nofit     = 1'b1;
      scsa_pkg::S_DONE:  cmd.out_load  = out_space;
      default: ;
    endcase
  end

  // Result valid flag: set on load, cleared when the result is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load)             out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scsa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/scsa_dpath.sv */
// ----------------------------------------------------------------------------
// scsa_dpath: allocator datapath
// Holds capacities, block state, slot occupancy rows, the scan counters,
// and the working and output result registers.
// ----------------------------------------------------------------------------
module scsa_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_operation,
  input  logic [scsa_pkg::SIZE_W-1:0]         in_request_size,
  input  logic [scsa_pkg::BLK_W-1:0]          in_block_index,
  input  logic [scsa_pkg::SLOT_W-1:0]         in_slot_index,
  input  logic                                cfg_we,
  input  logic [scsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  scsa_pkg::cmd_t                      cmd,
  output scsa_pkg::stat_t                     stat,
  output logic [1:0]                          out_status,
  output logic [scsa_pkg::BLK_W-1:0]          out_granted_block,
  output logic [scsa_pkg::SLOT_W-1:0]         out_granted_slot
);

  logic [scsa_pkg::SIZE_W-1:0]   tiny_cap_r, small_cap_r;
  logic                          op_r;
  logic [scsa_pkg::SIZE_W-1:0]   size_r;
  logic [scsa_pkg::BLK_W-1:0]    fblk_r;
  logic [scsa_pkg::SLOT_W-1:0]   fslot_r;
  logic [scsa_pkg::BLOCKS-1:0]   active_r, is_small_r;
  logic [scsa_pkg::ROW_W-1:0]    occ_r [scsa_pkg::BLOCKS];
  logic [scsa_pkg::BLK_W-1:0]    b_r;
  logic [scsa_pkg::CHUNK_W-1:0]  c_r;
  scsa_pkg::status_t             res_status_r, out_status_r;
  logic [scsa_pkg::BLK_W-1:0]    res_blk_r, out_blk_r;
  logic [scsa_pkg::SLOT_W-1:0]   res_slot_r, out_slot_r;

  logic [scsa_pkg::SIZE_W-1:0]   cap_sel;
  logic                          elig;
  logic [scsa_pkg::ROW_W-1:0]    row_sel;
  logic [scsa_pkg::CHUNK-1:0]    chunk_bits, free_vec;
  logic [scsa_pkg::CHUNK_B-1:0]  pos;
  logic [scsa_pkg::SLOT_W-1:0]   hit_slot;
  logic                          hit, blk_done;
  logic [scsa_pkg::BLK_W-1:0]    nb;
  logic                          none_free, want_tiny, want_small, open_ok;
  logic                          free_ok;

  // Chunk of the current block's occupancy row under scan
  assign cap_sel    = is_small_r[b_r] ? small_cap_r : tiny_cap_r;
  assign elig       = active_r[b_r] && (size_r <= cap_sel);
  assign row_sel    = occ_r[b_r];
  assign chunk_bits = row_sel[c_r*scsa_pkg::CHUNK +: scsa_pkg::CHUNK];

  // Free slots of the chunk that exist, and the lowest of them
  always_comb begin
    logic [scsa_pkg::SLOT_W-1:0] idx;
    free_vec = '0;
    pos      = '0;
    for (int i = 0; i < scsa_pkg::CHUNK; i++) begin
      idx = {c_r, scsa_pkg::CHUNK_B'(i)};
      free_vec[i] = !chunk_bits[i] && (idx < scsa_pkg::SLOT_W'(scsa_pkg::SLOTS));
    end
    for (int i = scsa_pkg::CHUNK - 1; i >= 0; i--) begin
      if (free_vec[i]) pos = scsa_pkg::CHUNK_B'(i);
    end
  end

  assign hit      = elig && (|free_vec);
  assign hit_slot = {c_r, pos};
  assign blk_done = !elig || ((c_r == scsa_pkg::CHUNK_W'(scsa_pkg::NCHUNK - 1)) && !hit);

  // Lowest inactive block for opening
  always_comb begin
    nb = '0;
    for (int i = scsa_pkg::BLOCKS - 1; i >= 0; i--) begin
      if (!active_r[i]) nb = scsa_pkg::BLK_W'(i);
    end
  end

  assign none_free  = &active_r;
  assign want_tiny  = size_r < tiny_cap_r;
  assign want_small = size_r < small_cap_r;
  assign open_ok    = (want_tiny || want_small) && !none_free;
  assign free_ok    = (fslot_r < scsa_pkg::SLOT_W'(scsa_pkg::SLOTS)) && active_r[fblk_r];

  // Status toward the controller
  assign stat.op_free    = (op_r == scsa_pkg::OP_FREE);
  assign stat.size_zero  = (size_r == '0);
  assign stat.any_active = |active_r;
  assign stat.hit        = hit;
  assign stat.scan_end   = blk_done && (b_r == scsa_pkg::BLK_W'(scsa_pkg::BLOCKS - 1));
  assign stat.rel_last   = (b_r == scsa_pkg::BLK_W'(scsa_pkg::BLOCKS - 1));

  // Capacity registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiny_cap_r  <= scsa_pkg::TINY_CAP_RESET;
      small_cap_r <= scsa_pkg::SMALL_CAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == scsa_pkg::REG_TINY_CAP)  tiny_cap_r  <= cfg_data;
      if (cfg_index == scsa_pkg::REG_SMALL_CAP) small_cap_r <= cfg_data;
    end
  end

  // Block state: activity and class
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= '0;
      is_small_r <= '0;
    end else begin
      if (cmd.open_first) begin
        active_r[0]   <= 1'b1;
        is_small_r[0] <= 1'b0;
      end
      if (cmd.rel_step && active_r[b_r] && (row_sel == '0)) begin
        active_r[b_r]   <= 1'b0;
        is_small_r[b_r] <= 1'b0;
      end
      if (cmd.nofit && open_ok) begin
        active_r[nb]   <= 1'b1;
        is_small_r[nb] <= !want_tiny;
      end
    end
  end

  // Slot occupancy rows; an opened row is cleared, or holds only slot 0 when opened on no fit
  always_ff @(posedge clk) begin
    if (cmd.free_clear && free_ok)  occ_r[fblk_r][fslot_r] <= 1'b0;
    if (cmd.open_first)             occ_r[0] <= '0;
    if (cmd.scan_step && hit)       occ_r[b_r][hit_slot] <= 1'b1;
    if (cmd.nofit && open_ok)       occ_r[nb] <= scsa_pkg::ROW_W'(1);
  end

  // Request capture and scan counters
  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      op_r    <= in_operation;
      size_r  <= in_request_size;
      fblk_r  <= in_block_index;
      fslot_r <= in_slot_index;
      b_r     <= '0;
      c_r     <= '0;
    end else if (cmd.rel_step) begin
      b_r <= b_r + 1'b1;
    end else if (cmd.scan_step && !hit) begin
      if (blk_done) begin
        b_r <= b_r + 1'b1;
        c_r <= '0;
      end else begin
        c_r <= c_r + 1'b1;
      end
    end
  end

  // Working result
  always_ff @(posedge clk) begin
    if (cmd.res_direct) begin
      res_status_r <= cmd.res_code;
      res_blk_r    <= '0;
      res_slot_r   <= '0;
    end else if (cmd.scan_step && hit) begin
      res_status_r <= scsa_pkg::ST_OK;
      res_blk_r    <= b_r;
      res_slot_r   <= hit_slot;
    end else if (cmd.nofit) begin
      res_blk_r  <= '0;
      res_slot_r <= '0;
      if (!(want_tiny || want_small)) begin
        res_status_r <= scsa_pkg::ST_TOO_LARGE;
      end else if (none_free) begin
        res_status_r <= scsa_pkg::ST_NO_BLOCK;
      end else begin
        res_status_r <= scsa_pkg::ST_OK;
        res_blk_r    <= nb;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_blk_r    <= res_blk_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_status        = out_status_r;
  assign out_granted_block = out_blk_r;
  assign out_granted_slot  = out_slot_r;

endmodule

/* rtl/size_class_slot_allocator.sv */
// ----------------------------------------------------------------------------
// size_class_slot_allocator: segregated-fit slab allocator
// Grants and frees slots in up to eight blocks of 100 slots each, with a
// tiny or small size class per block.
// ----------------------------------------------------------------------------
//   Channel   Dir  Contents
//   in_ch     in   operation, request_size, block_index, slot_index
//   out_ch    out  status, granted_block, granted_slot
//   cfg_*     in   write enable, register index, 16-bit data
//
// One transaction is worked on at a time. A free clears the slot, then
// makes one release check per block before its result is registered. An
// allocate scans the blocks in order, skipping an ineligible block whole
// and searching an eligible one in 8-slot chunks (up to 13 per block), and
// opens a new block when nothing fits. Reset clears block state and loads
// the reset capacities at once; no clearing pass is needed. A stalled
// result is held in its register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module size_class_slot_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  scsa_in_if.sink                           in_ch,
  scsa_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [scsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scsa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  scsa_pkg::cmd_t  cmd;
  scsa_pkg::stat_t stat;

  // Transaction sequencing
  scsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Allocator state and results
  scsa_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_ch.operation),
    .in_request_size   (in_ch.request_size),
    .in_block_index    (in_ch.block_index),
    .in_slot_index     (in_ch.slot_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_ch.status),
    .out_granted_block (out_ch.granted_block),
    .out_granted_slot  (out_ch.granted_slot)
  );

endmodule
